// ===== hw/rtl/lnv_pkg.sv =====
// ----------------------------------------------------------------------------
// lnv_pkg
// Types, codes and the reserved mnemonic table for the label name validator.
// ----------------------------------------------------------------------------
`default_nettype none

package lnv_pkg;

    // label length counter, saturating
    localparam int            LEN_W   = 7;
    localparam logic [LEN_W-1:0] LEN_SAT = 7'd127;

    // configuration register
    localparam int            MAXLEN_W        = 6;
    localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET = 6'd30;

    // mnemonic table geometry
    localparam int KW_TABLE_SIZE   = 16;
    localparam int KW_ROW          = 4;
    localparam int KW_ROW_W        = $clog2(KW_ROW);
    localparam int KEYWORD_MAX_LEN = 4;

    // reserved mnemonics, compared case-sensitively, zero padded
    localparam logic [7:0] KW_TEXT [KW_TABLE_SIZE][KW_ROW] = '{
        '{"m", "o", "v", 8'h00}, '{"c", "m", "p", 8'h00},
        '{"a", "d", "d", 8'h00}, '{"s", "u", "b", 8'h00},
        '{"n", "o", "t", 8'h00}, '{"c", "l", "r", 8'h00},
        '{"l", "e", "a", 8'h00}, '{"i", "n", "c", 8'h00},
        '{"d", "e", "c", 8'h00}, '{"j", "m", "p", 8'h00},
        '{"b", "n", "e", 8'h00}, '{"r", "e", "d", 8'h00},
        '{"p", "r", "n", 8'h00}, '{"j", "s", "r", 8'h00},
        '{"r", "t", "s", 8'h00}, '{"s", "t", "o", "p"}
    };

    localparam logic [2:0] KW_LEN [KW_TABLE_SIZE] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4
    };

    // result reason codes, in check order
    typedef enum logic [2:0] {
        REASON_OK               = 3'd0,
        REASON_TOO_LONG         = 3'd1,
        REASON_BAD_CHAR         = 3'd2,
        REASON_FIRST_NOT_LETTER = 3'd3,
        REASON_RESERVED         = 3'd4
    } reason_t;

    // one character step handed to the label state
    typedef struct packed {
        logic       commit;
        logic       last;
        logic [7:0] character;
    } step_t;

    // one label verdict
    typedef struct packed {
        logic    valid_res;
        reason_t reason;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lnv_in_if.sv =====
// ----------------------------------------------------------------------------
// lnv_in_if
// Character request channel: one label byte and an end-of-label flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface lnv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lnv_out_if.sv =====
// ----------------------------------------------------------------------------
// lnv_out_if
// Verdict request channel: pass flag and reason code for one label.
// ----------------------------------------------------------------------------
`default_nettype none

interface lnv_out_if;
    logic       valid;
    logic       ready;
    logic       valid_res;
    logic [2:0] reason;

    modport source (output valid, output valid_res, output reason, input ready);
    modport sink   (input valid, input valid_res, input reason, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/lnv_keyword_match.sv =====
// ----------------------------------------------------------------------------
// lnv_keyword_match
// Parallel compare of one character against each of the first NKW reserved
// mnemonics at the current position; narrows the match mask and flags a whole-label hit.
// ----------------------------------------------------------------------------
`default_nettype none

module lnv_keyword_match #(
    parameter int NKW = 16
) (
    input  wire logic [lnv_pkg::LEN_W-1:0] pos,
    input  wire logic [lnv_pkg::LEN_W-1:0] len_next,
    input  wire logic [7:0]                character,
    input  wire logic [NKW-1:0]            mask,
    output logic      [NKW-1:0]            mask_next,
    output logic                           kw_hit
);

    // per-mnemonic keep and exact-length hit
    always_comb
    begin
        kw_hit = 1'b0;
        for (int k = 0; k < NKW; k++)
        begin
            mask_next[k] = mask[k]
                && (pos < lnv_pkg::LEN_W'(lnv_pkg::KW_LEN[k]))
                && (pos < lnv_pkg::LEN_W'(lnv_pkg::KEYWORD_MAX_LEN))
                && (pos < lnv_pkg::LEN_W'(lnv_pkg::KW_ROW))
                && (lnv_pkg::KW_TEXT[k][pos[lnv_pkg::KW_ROW_W-1:0]] == character);
            if (mask_next[k] && (lnv_pkg::LEN_W'(lnv_pkg::KW_LEN[k]) == len_next))
            begin
                kw_hit = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lnv_label_state.sv =====
// ----------------------------------------------------------------------------
// lnv_label_state
// Per-label state (length, bad character, leading letter, mnemonic mask)
// and the ranked verdict formed on the last character.
// ----------------------------------------------------------------------------
`default_nettype none

module lnv_label_state #(
    parameter int NKW = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire lnv_pkg::step_t                step,
    input  wire logic [lnv_pkg::MAXLEN_W-1:0]  max_length,
    output lnv_pkg::result_t                   result
);

    logic [lnv_pkg::LEN_W-1:0] length_count_reg, length_count_next;
    logic                      bad_char_seen_reg, bad_char_seen_next;
    logic                      first_is_letter_reg, first_is_letter_next;
    logic [NKW-1:0]            kw_mask_reg, kw_mask_next;
    logic                      is_letter, is_digit, kw_hit;

    // character class
    always_comb
    begin
        is_letter = ((step.character >= "A") && (step.character <= "Z"))
                 || ((step.character >= "a") && (step.character <= "z"));
        is_digit  = (step.character >= "0") && (step.character <= "9");
    end

    lnv_keyword_match #(
        .NKW (NKW)
    ) u_kw (
        .pos       (length_count_reg),
        .len_next  (length_count_next),
        .character (step.character),
        .mask      (kw_mask_reg),
        .mask_next (kw_mask_next),
        .kw_hit    (kw_hit)
    );

    // state update for this character
    always_comb
    begin
        length_count_next    = (length_count_reg == lnv_pkg::LEN_SAT)
                             ? length_count_reg
                             : length_count_reg + lnv_pkg::LEN_W'(1);
        bad_char_seen_next   = bad_char_seen_reg | ~(is_letter | is_digit);
        first_is_letter_next = (length_count_reg == '0) ? is_letter : first_is_letter_reg;
    end

    // ranked checks
    always_comb
    begin
        if (length_count_next > lnv_pkg::LEN_W'(max_length))
        begin
            result.reason = lnv_pkg::REASON_TOO_LONG;
        end
        else if (bad_char_seen_next)
        begin
            result.reason = lnv_pkg::REASON_BAD_CHAR;
        end
        else if (!first_is_letter_next)
        begin
            result.reason = lnv_pkg::REASON_FIRST_NOT_LETTER;
        end
        else if (kw_hit)
        begin
            result.reason = lnv_pkg::REASON_RESERVED;
        end
        else
        begin
            result.reason = lnv_pkg::REASON_OK;
        end
        result.valid_res = (result.reason == lnv_pkg::REASON_OK);
    end

    // state registers, cleared at the end of each label
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_count_reg    <= '0;
            bad_char_seen_reg   <= 1'b0;
            first_is_letter_reg <= 1'b0;
            kw_mask_reg         <= '1;
        end
        else if (step.commit)
        begin
            if (step.last)
            begin
                length_count_reg    <= '0;
                bad_char_seen_reg   <= 1'b0;
                first_is_letter_reg <= 1'b0;
                kw_mask_reg         <= '1;
            end
            else
            begin
                length_count_reg    <= length_count_next;
                bad_char_seen_reg   <= bad_char_seen_next;
                first_is_letter_reg <= first_is_letter_next;
                kw_mask_reg         <= kw_mask_next;
            end
        end
    end

    // checks
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step.commit && step.last |=> length_count_reg == '0 && kw_mask_reg == '1)
        else $error("label state not cleared after last character");

    a_len_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        step.commit && !step.last && length_count_reg == lnv_pkg::LEN_SAT
        |=> length_count_reg == lnv_pkg::LEN_SAT)
        else $error("length counter wrapped");

    a_bad_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        bad_char_seen_reg && !(step.commit && step.last) |=> bad_char_seen_reg)
        else $error("bad character flag dropped inside a label");

endmodule

`default_nettype wire

// ===== hw/rtl/label_name_validator.sv =====
// ----------------------------------------------------------------------------
// label_name_validator
// Checks an assembler label streamed one character per request and returns
// a pass flag and reason code on the last character.
// ----------------------------------------------------------------------------
// the last character passes the input register and then the result register before the verdict request
// throughput: 1 character per cycle, unless a last character waits for a held verdict; set by the
//   input register feeding the per-character checks and the parallel mnemonic compare in one pass
// reset: asynchronous, clears label state, empties both registers and sets
//   max_length to 30; no clearing pass, characters are taken right away
`default_nettype none

module label_name_validator #(
    parameter int NUM_KEYWORDS = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [5:0] cfg_wr_data,
    lnv_in_if.sink          in_ch,
    lnv_out_if.source       out_ch
);

    localparam int NKW = (NUM_KEYWORDS < lnv_pkg::KW_TABLE_SIZE)
                       ? NUM_KEYWORDS : lnv_pkg::KW_TABLE_SIZE;

    logic [lnv_pkg::MAXLEN_W-1:0] max_length_reg;
    logic                         s1_valid_reg;
    logic [7:0]                   s1_char_reg;
    logic                         s1_last_reg;
    logic                         s1_advance;
    logic                         out_valid_reg;
    lnv_pkg::result_t             out_res_reg;
    lnv_pkg::result_t             result;
    lnv_pkg::step_t               step;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= lnv_pkg::MAX_LENGTH_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_length_reg <= cfg_wr_data;
        end
    end

    // a character moves on unless it ends a label and the verdict slot is held
    always_comb
    begin
        s1_advance     = !s1_last_reg || !out_valid_reg || out_ch.ready;
        in_ch.ready    = !s1_valid_reg || s1_advance;
        step.commit    = s1_valid_reg && s1_advance;
        step.last      = s1_last_reg;
        step.character = s1_char_reg;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_char_reg <= in_ch.character;
            s1_last_reg <= in_ch.last;
        end
    end

    lnv_label_state #(
        .NKW (NKW)
    ) u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .max_length (max_length_reg),
        .result     (result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step.commit && step.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.commit && step.last)
        begin
            out_res_reg <= result;
        end
    end

    // output request
    always_comb
    begin
        out_ch.valid     = out_valid_reg;
        out_ch.valid_res = out_res_reg.valid_res;
        out_ch.reason    = out_res_reg.reason;
    end

    // checks
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input stalled with an empty result register");

    a_pass_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.valid_res == (out_ch.reason == lnv_pkg::REASON_OK))
        else $error("pass flag disagrees with reason code");

    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg && $stable(s1_char_reg))
        else $error("stalled character lost from the input register");

endmodule

`default_nettype wire
